// ----- sv/bpm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Breakpoint match table package
// Operation, status, outcome and mode codes, plus controller/datapath types.
// ----------------------------------------------------------------------------
package bpm_pkg;

  localparam int ID_W     = 16;
  localparam int PC_W     = 32;
  localparam int FRAME_W  = 32;
  localparam int MASK_W   = 16;
  localparam int REMOVE_W = 5;

  localparam logic [3:0] OP_ADD     = 4'd0;
  localparam logic [3:0] OP_MODE    = 4'd1;
  localparam logic [3:0] OP_IGNORE  = 4'd2;
  localparam logic [3:0] OP_FLAGS   = 4'd3;
  localparam logic [3:0] OP_DELETE  = 4'd4;
  localparam logic [3:0] OP_CLEAR   = 4'd5;
  localparam logic [3:0] OP_DEL_ALL = 4'd6;
  localparam logic [3:0] OP_CHECK   = 4'd7;
  localparam logic [3:0] OP_QUERY   = 4'd8;
  localparam logic [3:0] OP_AUTODEL = 4'd9;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NOID = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [1:0] OC_NONE = 2'd0;
  localparam logic [1:0] OC_CONT = 2'd1;
  localparam logic [1:0] OC_STOP = 2'd2;
  localparam logic [1:0] OC_MOM  = 2'd3;

  localparam logic [1:0] MODE_DIS  = 2'd0;
  localparam logic [1:0] MODE_EN   = 2'd1;
  localparam logic [1:0] MODE_TEMP = 2'd2;
  localparam logic [1:0] MODE_DEL  = 2'd3;

  typedef struct packed {
    logic start;
    logic step;
    logic load_out;
  } bpm_cmd_t;

  typedef struct packed {
    logic done;
  } bpm_sts_t;

endpackage
`default_nettype wire

// ----- sv/bpm_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Breakpoint match table input channel
// Valid/ready channel carrying one operation word.
// ----------------------------------------------------------------------------
interface bpm_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  operation;
  logic [15:0] bp_id;
  logic [31:0] address;
  logic [31:0] frame_id;
  logic [1:0]  mode;
  logic [15:0] ignore_value;
  logic        cond_flag;
  logic        silent_flag;
  logic [15:0] cond_false_mask;
  logic        commands_pending;

  modport source (output valid, operation, bp_id, address, frame_id, mode, ignore_value,
                  cond_flag, silent_flag, cond_false_mask, commands_pending, input ready);
  modport sink (input valid, operation, bp_id, address, frame_id, mode, ignore_value,
                cond_flag, silent_flag, cond_false_mask, commands_pending, output ready);
endinterface
`default_nettype wire

// ----- sv/bpm_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Breakpoint match table result channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface bpm_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [1:0]  outcome;
  logic [15:0] hit_number;
  logic        hit_silent;
  logic        present;
  logic [4:0]  removed_count;

  modport source (output valid, status, outcome, hit_number, hit_silent, present,
                  removed_count, input ready);
  modport sink (input valid, status, outcome, hit_number, hit_silent, present,
                removed_count, output ready);
endinterface
`default_nettype wire

// ----- sv/bpm_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Breakpoint match table controller
// Sequences accept, slot scan and result hand-off.
// ----------------------------------------------------------------------------
module bpm_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output bpm_pkg::bpm_cmd_t     cmd,
  input  wire bpm_pkg::bpm_sts_t sts
);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_POST} state_t;

  state_t state_r;
  logic   out_valid_r;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.start    = (state_r == S_IDLE) && in_valid;
    cmd.step     = (state_r == S_RUN);
    cmd.load_out = (state_r == S_POST) && (!out_valid_r || out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_POST && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) state_r <= S_RUN;
        end
        S_RUN: begin
          if (sts.done) state_r <= S_POST;
        end
        S_POST: begin
          if (!out_valid_r || out_ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- sv/bpm_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Breakpoint match table datapath
// Packed slot table, scan pointer, one slot comparator and result registers.
// ----------------------------------------------------------------------------
module bpm_dp #(
  parameter int ENTRIES   = 16,
  parameter int ADDR_BITS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [3:0]        cfg_wdata,
  input  wire logic [3:0]        i_operation,
  input  wire logic [15:0]       i_bp_id,
  input  wire logic [31:0]       i_address,
  input  wire logic [31:0]       i_frame_id,
  input  wire logic [1:0]        i_mode,
  input  wire logic [15:0]       i_ignore_value,
  input  wire logic              i_cond_flag,
  input  wire logic              i_silent_flag,
  input  wire logic [15:0]       i_cond_false_mask,
  input  wire logic              i_commands_pending,
  output logic [1:0]             o_status,
  output logic [1:0]             o_outcome,
  output logic [15:0]            o_hit_number,
  output logic                   o_hit_silent,
  output logic                   o_present,
  output logic [4:0]             o_removed_count,
  input  wire bpm_pkg::bpm_cmd_t cmd,
  output bpm_pkg::bpm_sts_t      sts
);

  localparam int AW = (ADDR_BITS < 32) ? ADDR_BITS : 32;
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  typedef struct packed {
    logic [15:0]   number;
    logic [AW-1:0] addr;
    logic [1:0]    mode;
    logic [15:0]   ignore;
    logic [31:0]   frame;
    logic          has_cond;
    logic          silent;
    logic          momentary;
  } entry_t;

  entry_t        ent_r   [ENTRIES];
  entry_t        ent_nxt [ENTRIES];
  logic [CW-1:0] used_r, used_nxt, i_r, i_nxt;
  logic [15:0]   last_r, last_nxt;
  logic [3:0]    pc_adj_r;
  logic [3:0]    op_r;
  logic [15:0]   id_r;
  logic [AW-1:0] addr_r;
  logic [31:0]   frame_r;
  logic [1:0]    mode_r;
  logic [15:0]   ign_r;
  logic          cf_r, sf_r, pend_r;
  logic [15:0]   mask_r;
  logic          phase_r, phase_nxt;
  logic [1:0]    status_r, status_nxt, outcome_r, outcome_nxt;
  logic [15:0]   hitn_r, hitn_nxt;
  logic          hits_r, hits_nxt, pres_r, pres_nxt;
  logic [4:0]    removed_r, removed_nxt, rem_inc;
  logic          inr, rm, mask_hit;
  logic [IW-1:0] idx;
  logic [6:0]    i_ext;
  logic [AW-1:0] pc;
  entry_t        cur, added;

  always_comb begin
    idx      = i_r[IW-1:0];
    inr      = (i_r < used_r);
    cur      = ent_r[idx];
    i_ext    = 7'(i_r);
    mask_hit = (i_ext < 7'd16) && mask_r[i_ext[3:0]];
    pc       = addr_r - AW'(pc_adj_r);
    rem_inc  = (removed_r == 5'd31) ? 5'd31 : removed_r + 5'd1;

    for (int j = 0; j < ENTRIES; j++) ent_nxt[j] = ent_r[j];
    used_nxt    = used_r;
    last_nxt    = last_r;
    i_nxt       = i_r;
    phase_nxt   = phase_r;
    status_nxt  = status_r;
    outcome_nxt = outcome_r;
    hitn_nxt    = hitn_r;
    hits_nxt    = hits_r;
    pres_nxt    = pres_r;
    removed_nxt = removed_r;
    rm          = 1'b0;
    sts.done    = 1'b0;

    added           = cur;
    added.addr      = addr_r;
    added.frame     = frame_r;
    added.ignore    = '0;
    added.has_cond  = 1'b0;
    added.silent    = 1'b0;
    added.momentary = (mode_r == bpm_pkg::MODE_DEL);
    added.number    = '0;
    added.mode      = bpm_pkg::MODE_DEL;

    if (cmd.start) begin
      i_nxt       = '0;
      phase_nxt   = 1'b0;
      status_nxt  = bpm_pkg::ST_OK;
      outcome_nxt = bpm_pkg::OC_NONE;
      hitn_nxt    = '0;
      hits_nxt    = 1'b0;
      pres_nxt    = 1'b0;
      removed_nxt = '0;
    end else if (cmd.step) begin
      case (op_r)
        bpm_pkg::OP_ADD: begin
          sts.done = 1'b1;
          if (int'(used_r) >= ENTRIES) begin
            status_nxt = bpm_pkg::ST_FULL;
          end else begin
            if (mode_r != bpm_pkg::MODE_DEL) begin
              last_nxt     = last_r + 16'd1;
              added.number = last_nxt;
              added.mode   = (mode_r == bpm_pkg::MODE_TEMP) ? bpm_pkg::MODE_TEMP
                                                            : bpm_pkg::MODE_EN;
              hitn_nxt     = last_nxt;
            end
            ent_nxt[used_r[IW-1:0]] = added;
            used_nxt = used_r + CW'(1);
          end
        end
        bpm_pkg::OP_MODE, bpm_pkg::OP_IGNORE, bpm_pkg::OP_FLAGS, bpm_pkg::OP_DELETE: begin
          if (!inr) begin
            sts.done   = 1'b1;
            status_nxt = bpm_pkg::ST_NOID;
          end else if (!cur.momentary && cur.number == id_r) begin
            sts.done = 1'b1;
            case (op_r)
              bpm_pkg::OP_MODE:   ent_nxt[idx].mode = mode_r;
              bpm_pkg::OP_IGNORE: ent_nxt[idx].ignore = ign_r;
              bpm_pkg::OP_FLAGS: begin
                ent_nxt[idx].has_cond = cf_r;
                ent_nxt[idx].silent   = sf_r;
              end
              default: begin
                rm          = 1'b1;
                removed_nxt = 5'd1;
              end
            endcase
          end else begin
            i_nxt = i_r + CW'(1);
          end
        end
        bpm_pkg::OP_CLEAR: begin
          if (!inr) begin
            sts.done = 1'b1;
            if (removed_r == '0) status_nxt = bpm_pkg::ST_NOID;
          end else if (cur.addr == addr_r) begin
            rm          = 1'b1;
            removed_nxt = rem_inc;
          end else begin
            i_nxt = i_r + CW'(1);
          end
        end
        bpm_pkg::OP_DEL_ALL: begin
          sts.done    = 1'b1;
          removed_nxt = (int'(used_r) > 31) ? 5'd31 : 5'(used_r);
          used_nxt    = '0;
        end
        bpm_pkg::OP_CHECK: begin
          if (!inr) begin
            sts.done = 1'b1;
          end else if (cur.mode != bpm_pkg::MODE_DIS && cur.addr == pc) begin
            if (cur.frame != '0 && cur.frame != frame_r) begin
              outcome_nxt = bpm_pkg::OC_CONT;
              i_nxt       = i_r + CW'(1);
            end else if (cur.has_cond && mask_hit) begin
              outcome_nxt = bpm_pkg::OC_CONT;
              i_nxt       = i_r + CW'(1);
            end else if (cur.ignore != '0) begin
              ent_nxt[idx].ignore = cur.ignore - 16'd1;
              outcome_nxt = bpm_pkg::OC_CONT;
              i_nxt       = i_r + CW'(1);
            end else begin
              sts.done = 1'b1;
              if (cur.mode == bpm_pkg::MODE_TEMP) ent_nxt[idx].mode = bpm_pkg::MODE_DIS;
              if (cur.momentary) begin
                outcome_nxt = bpm_pkg::OC_MOM;
              end else begin
                outcome_nxt = bpm_pkg::OC_STOP;
                hitn_nxt    = cur.number;
                hits_nxt    = cur.silent;
              end
            end
          end else begin
            i_nxt = i_r + CW'(1);
          end
        end
        bpm_pkg::OP_QUERY: begin
          if (!inr) begin
            sts.done = 1'b1;
          end else if (cur.mode != bpm_pkg::MODE_DIS && cur.addr == addr_r) begin
            sts.done = 1'b1;
            pres_nxt = 1'b1;
          end else begin
            i_nxt = i_r + CW'(1);
          end
        end
        bpm_pkg::OP_AUTODEL: begin
          if (!phase_r) begin
            if (id_r == '0 || !inr) begin
              phase_nxt = 1'b1;
              i_nxt     = '0;
            end else if (!cur.momentary && cur.number == id_r) begin
              if (cur.mode == bpm_pkg::MODE_DEL) begin
                rm          = 1'b1;
                removed_nxt = rem_inc;
              end
              phase_nxt = 1'b1;
              i_nxt     = '0;
            end else begin
              i_nxt = i_r + CW'(1);
            end
          end else if (pend_r || !inr) begin
            sts.done = 1'b1;
          end else if (cur.momentary) begin
            sts.done    = 1'b1;
            rm          = 1'b1;
            removed_nxt = rem_inc;
          end else begin
            i_nxt = i_r + CW'(1);
          end
        end
        default: sts.done = 1'b1;
      endcase
    end

    if (rm) begin
      for (int j = 0; j < ENTRIES - 1; j++) begin
        if (CW'(j) >= i_r) ent_nxt[j] = ent_r[j + 1];
      end
      used_nxt = used_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r   <= '0;
      last_r   <= '0;
      pc_adj_r <= '0;
    end else begin
      used_r <= used_nxt;
      last_r <= last_nxt;
      if (cfg_we) pc_adj_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < ENTRIES; j++) ent_r[j] <= ent_nxt[j];
    i_r       <= i_nxt;
    phase_r   <= phase_nxt;
    status_r  <= status_nxt;
    outcome_r <= outcome_nxt;
    hitn_r    <= hitn_nxt;
    hits_r    <= hits_nxt;
    pres_r    <= pres_nxt;
    removed_r <= removed_nxt;
    if (cmd.start) begin
      op_r    <= i_operation;
      id_r    <= i_bp_id;
      addr_r  <= i_address[AW-1:0];
      frame_r <= i_frame_id;
      mode_r  <= i_mode;
      ign_r   <= i_ignore_value;
      cf_r    <= i_cond_flag;
      sf_r    <= i_silent_flag;
      mask_r  <= i_cond_false_mask;
      pend_r  <= i_commands_pending;
    end
    if (cmd.load_out) begin
      o_status        <= status_r;
      o_outcome       <= outcome_r;
      o_hit_number    <= hitn_r;
      o_hit_silent    <= hits_r;
      o_present       <= pres_r;
      o_removed_count <= removed_r;
    end
  end

endmodule
`default_nettype wire

// ----- sv/breakpoint_match_table.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Breakpoint match table
// Ordered breakpoint table with add, edit, remove, check and query words.
// A word visits the table one slot at a time; removal shifts later slots down in the same cycle.
// When the scan finishes, S_POST loads the result registers and raises out_valid once the
// output is free; the next word is accepted only back in S_IDLE. An add needs no scan.
// An auto delete scans the table twice, first for the numbered slot, then for momentary ones.
// Synchronous reset empties the table, zeroes the number counter and pc_adjust.
// ----------------------------------------------------------------------------
module breakpoint_match_table #(
  parameter int ENTRIES   = 16,
  parameter int ADDR_BITS = 32
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [3:0] cfg_wdata,
  bpm_in_if.sink          in_word,
  bpm_out_if.source       out_word
);

  bpm_pkg::bpm_cmd_t cmd;
  bpm_pkg::bpm_sts_t sts;

  bpm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_word.valid),
    .in_ready  (in_word.ready),
    .out_valid (out_word.valid),
    .out_ready (out_word.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  bpm_dp #(
    .ENTRIES   (ENTRIES),
    .ADDR_BITS (ADDR_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .i_operation        (in_word.operation),
    .i_bp_id            (in_word.bp_id),
    .i_address          (in_word.address),
    .i_frame_id         (in_word.frame_id),
    .i_mode             (in_word.mode),
    .i_ignore_value     (in_word.ignore_value),
    .i_cond_flag        (in_word.cond_flag),
    .i_silent_flag      (in_word.silent_flag),
    .i_cond_false_mask  (in_word.cond_false_mask),
    .i_commands_pending (in_word.commands_pending),
    .o_status           (out_word.status),
    .o_outcome          (out_word.outcome),
    .o_hit_number       (out_word.hit_number),
    .o_hit_silent       (out_word.hit_silent),
    .o_present          (out_word.present),
    .o_removed_count    (out_word.removed_count),
    .cmd                (cmd),
    .sts                (sts)
  );

endmodule
`default_nettype wire
